[hw/rtl/sxt_pkg.sv]
// Shared types and constants for the s-expression tokenizer.
// Used by sxt_scan, sxt_outq and s_expression_tokenizer; no dependencies.
`default_nettype none

package sxt_pkg;

    // Default longest line, in characters
    localparam int MAX_LINE_DEF = 4096;

    // Fixed field widths of a result beat
    localparam int POS_OUT_W = 12;
    localparam int LEN_W     = 13;
    localparam int LEN_MAX   = 8191;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // Character codes
    localparam logic [7:0] CH_LPAR    = 8'h28;
    localparam logic [7:0] CH_RPAR    = 8'h29;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_UPPER_T = 8'h54;

    // Input action codes
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_EOL  = 1'b1;

    typedef enum logic [2:0] {
        KIND_OPEN   = 3'd0,
        KIND_CLOSE  = 3'd1,
        KIND_NIL    = 3'd2,
        KIND_NUMBER = 3'd3,
        KIND_STRING = 3'd4,
        KIND_SYMBOL = 3'd5,
        KIND_QUOTE  = 3'd6,
        KIND_TRUE   = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [POS_OUT_W-1:0]   start_pos;
        logic [LEN_W-1:0]       token_len;
        logic                   unmatched_quote;
        logic                   line_overflow;
        logic                   last_of_run;
    } t_tok;

    // Results of one accepted beat, pushed into the queue together
    typedef struct packed {
        logic [1:0] cnt;
        t_tok       tok0;
        t_tok       tok1;
    } t_push;

endpackage

`default_nettype wire

[hw/rtl/s_expression_tokenizer.sv]
// Top level of the s-expression tokenizer: scanner plus result queue.
// Depends on sxt_pkg, sxt_scan and sxt_outq.
//
// Usage:
//   Input channel (i_valid / o_stall): one beat is either a character of the
//   line (i_action = 0, byte on i_char_code) or an end of line (i_action = 1).
//   A beat is taken at a rising edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall): one beat per token, giving kind, start
//   offset, length and flags; o_last_of_run marks the final token of a beat.
//   Result path: a token caused by a beat is written into the result queue
//   when that beat is taken and is presented once it reaches the queue head.
//   Throughput: one input beat per cycle while o_stall is low; the output
//   port drains one token per cycle while i_stall is low. A beat can yield
//   two tokens (a close paren or quote after an atom, a quote after an open
//   paren). A four-entry result queue sits between the two sides; o_stall
//   rises while it holds more than two tokens. Scanner state is registered.
//   Output stall: tokens wait in the queue with the head held steady; the
//   input keeps flowing until the queue is near full.
//   Reset (synchronous, active low): empty the queue, return to idle between
//   tokens at line offset zero with the overflow flag clear.
`default_nettype none

module s_expression_tokenizer #(
    parameter int MAX_LINE = sxt_pkg::MAX_LINE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_action,
    input  wire logic [7:0]                    i_char_code,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [2:0]                         o_token_kind,
    output logic [sxt_pkg::POS_OUT_W-1:0]      o_start_pos,
    output logic [sxt_pkg::LEN_W-1:0]          o_token_len,
    output logic                               o_unmatched_quote,
    output logic                               o_line_overflow,
    output logic                               o_last_of_run
);
    import sxt_pkg::*;

    t_push             push;
    t_tok              head;
    logic              in_fire;
    logic              out_fire;
    logic              no_room;
    logic [Q_CW-1:0]   q_cnt;

    // Take a beat only while the queue can absorb two tokens
    assign in_fire  = i_valid && !no_room;
    assign out_fire = o_valid && !i_stall;
    assign o_stall  = no_room;

    sxt_scan #(
        .MAX_LINE (MAX_LINE)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_action    (i_action),
        .i_char_code (i_char_code),
        .o_push      (push)
    );

    sxt_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_pop     (out_fire),
        .o_head    (head),
        .o_valid   (o_valid),
        .o_no_room (no_room),
        .o_cnt     (q_cnt)
    );

    // Drive the output beat from the queue head
    assign o_token_kind      = head.kind;
    assign o_start_pos       = head.start_pos;
    assign o_token_len       = head.token_len;
    assign o_unmatched_quote = head.unmatched_quote;
    assign o_line_overflow   = head.line_overflow;
    assign o_last_of_run     = head.last_of_run;

    // Tokens appear only from an accepted beat
    a_push_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt != 2'd0) |-> in_fire)
        else $error("tokens produced without an accepted beat");

    // An accepted beat always finds room for two tokens
    a_room_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (q_cnt <= Q_CW'(Q_DEPTH - 2)))
        else $error("beat accepted without queue room");

    // Single-character tokens carry length one
    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (head.kind == KIND_OPEN || head.kind == KIND_CLOSE ||
                     head.kind == KIND_QUOTE)) |-> (head.token_len == LEN_W'(1)))
        else $error("paren or quote token with wrong length");

    // Nil spans exactly the two parens
    a_nil_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && head.kind == KIND_NIL) |-> (head.token_len == LEN_W'(2)))
        else $error("nil token with wrong length");

    // Only a string can be flagged as unterminated
    a_unmatched_is_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && head.unmatched_quote) |-> (head.kind == KIND_STRING && head.last_of_run))
        else $error("unmatched quote flag on a non-string token");

endmodule

`default_nettype wire

[hw/rtl/sxt_scan.sv]
// Character scanner: mode register, line position and pending-token state.
// Turns one accepted beat into zero, one or two result tokens. Uses sxt_pkg.
`default_nettype none

module sxt_scan #(
    parameter int MAX_LINE = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic          i_action,
    input  wire logic [7:0]    i_char_code,
    output sxt_pkg::t_push     o_push
);
    import sxt_pkg::*;

    localparam int POS_W = $clog2(MAX_LINE);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);
    localparam logic [LEN_W-1:0] LEN_CAP =
        LEN_W'((MAX_LINE < LEN_MAX) ? MAX_LINE : LEN_MAX);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ATOM  = 2'd1,
        MODE_STR   = 2'd2,
        MODE_PAREN = 2'd3
    } t_mode;

    t_mode              r_mode,      n_mode;
    logic [POS_W-1:0]   r_line_pos,  n_line_pos;
    logic [POS_W-1:0]   r_tok_start, n_tok_start;
    logic [LEN_W-1:0]   r_len,       n_len;
    logic [7:0]         r_first,     n_first;
    logic               r_num,       n_num;
    logic               r_dot,       n_dot;
    logic               r_ovf,       n_ovf;

    t_tok               res [2];
    logic [1:0]         cnt;
    logic               go_idle;
    logic               ovf_cur;
    logic [7:0]         c;
    logic [POS_W-1:0]   pos;

    function automatic logic [POS_OUT_W-1:0] to_out(input logic [POS_W-1:0] p);
        logic [POS_W+POS_OUT_W-1:0] ext;
        ext = {{POS_OUT_W{1'b0}}, p};
        return ext[POS_OUT_W-1:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch inside {8'd32, [8'd9:8'd13]});
    endfunction

    function automatic logic is_sep(input logic [7:0] ch);
        return is_space(ch) || (ch inside {CH_LPAR, CH_RPAR, CH_DQUOTE, CH_SQUOTE});
    endfunction

    function automatic t_kind atom_kind(input logic num, input logic [7:0] fc,
                                        input logic [LEN_W-1:0] len);
        logic is_num;
        is_num = num && !(fc == CH_MINUS && len < LEN_W'(2));
        if (is_num) begin
            return KIND_NUMBER;
        end
        if (len == LEN_W'(1) && (fc == CH_LOWER_T || fc == CH_UPPER_T)) begin
            return KIND_TRUE;
        end
        return KIND_SYMBOL;
    endfunction

    function automatic t_tok mk_tok(input t_kind k, input logic [POS_W-1:0] s,
                                    input logic [LEN_W-1:0] l, input logic unm,
                                    input logic ovf);
        t_tok t;
        t.kind            = k;
        t.start_pos       = to_out(s);
        t.token_len       = l;
        t.unmatched_quote = unm;
        t.line_overflow   = ovf;
        t.last_of_run     = 1'b0;
        return t;
    endfunction

    always_comb begin
        n_mode      = r_mode;
        n_line_pos  = r_line_pos;
        n_tok_start = r_tok_start;
        n_len       = r_len;
        n_first     = r_first;
        n_num       = r_num;
        n_dot       = r_dot;
        n_ovf       = r_ovf;
        res[0]      = '0;
        res[1]      = '0;
        cnt         = 2'd0;
        go_idle     = 1'b0;
        c           = i_char_code;
        pos         = r_line_pos;
        ovf_cur     = r_ovf;

        if (i_fire && i_action == ACT_EOL) begin
            // Flush whatever is pending, then clear the line
            case (r_mode)
                MODE_ATOM: begin
                    res[0] = mk_tok(atom_kind(r_num, r_first, r_len), r_tok_start,
                                    r_len, 1'b0, r_ovf);
                    cnt    = 2'd1;
                end
                MODE_PAREN: begin
                    res[0] = mk_tok(KIND_OPEN, r_tok_start, LEN_W'(1), 1'b0, r_ovf);
                    cnt    = 2'd1;
                end
                MODE_STR: begin
                    res[0] = mk_tok(KIND_STRING, r_tok_start, r_len, 1'b1, r_ovf);
                    cnt    = 2'd1;
                end
                default: begin
                    cnt = 2'd0;
                end
            endcase
            n_mode      = MODE_IDLE;
            n_line_pos  = '0;
            n_tok_start = '0;
            n_len       = '0;
            n_first     = '0;
            n_num       = 1'b0;
            n_dot       = 1'b0;
            n_ovf       = 1'b0;
        end else if (i_fire) begin
            // Advance the position, or saturate and flag
            if (r_line_pos != POS_LAST) begin
                n_line_pos = r_line_pos + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
            ovf_cur = n_ovf;

            case (r_mode)
                MODE_ATOM: begin
                    if (is_sep(c)) begin
                        res[0]  = mk_tok(atom_kind(r_num, r_first, r_len), r_tok_start,
                                         r_len, 1'b0, ovf_cur);
                        cnt     = 2'd1;
                        go_idle = 1'b1;
                    end else begin
                        if (r_len == LEN_W'(1) && r_first == CH_MINUS && !is_digit(c)) begin
                            n_num = 1'b0;
                        end
                        if (!is_digit(c)) begin
                            if (c == CH_DOT && !r_dot) begin
                                n_dot = 1'b1;
                            end else begin
                                n_num = 1'b0;
                            end
                        end
                        if (r_len < LEN_CAP) begin
                            n_len = r_len + 1'b1;
                        end
                    end
                end
                MODE_STR: begin
                    if (c == CH_DQUOTE) begin
                        res[0] = mk_tok(KIND_STRING, r_tok_start, r_len, 1'b0, ovf_cur);
                        cnt    = 2'd1;
                        n_mode = MODE_IDLE;
                    end else if (r_len < LEN_CAP) begin
                        n_len = r_len + 1'b1;
                    end
                end
                MODE_PAREN: begin
                    if (c == CH_RPAR) begin
                        res[0] = mk_tok(KIND_NIL, r_tok_start, LEN_W'(2), 1'b0, ovf_cur);
                        cnt    = 2'd1;
                        n_mode = MODE_IDLE;
                    end else begin
                        res[0]  = mk_tok(KIND_OPEN, r_tok_start, LEN_W'(1), 1'b0, ovf_cur);
                        cnt     = 2'd1;
                        go_idle = 1'b1;
                    end
                end
                default: begin
                    go_idle = 1'b1;
                end
            endcase

            // Handle the character as if nothing were pending
            if (go_idle) begin
                n_mode = MODE_IDLE;
                if (is_space(c)) begin
                    n_mode = MODE_IDLE;
                end else if (c == CH_DQUOTE) begin
                    n_mode      = MODE_STR;
                    n_tok_start = (pos == POS_LAST) ? pos : pos + 1'b1;
                    n_len       = '0;
                end else if (c == CH_LPAR) begin
                    n_mode      = MODE_PAREN;
                    n_tok_start = pos;
                end else if (c == CH_RPAR) begin
                    res[cnt[0]] = mk_tok(KIND_CLOSE, pos, LEN_W'(1), 1'b0, ovf_cur);
                    cnt         = cnt + 2'd1;
                end else if (c == CH_SQUOTE) begin
                    res[cnt[0]] = mk_tok(KIND_QUOTE, pos, LEN_W'(1), 1'b0, ovf_cur);
                    cnt         = cnt + 2'd1;
                end else begin
                    n_mode      = MODE_ATOM;
                    n_tok_start = pos;
                    n_len       = LEN_W'(1);
                    n_first     = c;
                    n_num       = is_digit(c) || (c == CH_MINUS);
                    n_dot       = 1'b0;
                end
            end
        end

        // Mark the final result of this beat
        if (cnt == 2'd1) begin
            res[0].last_of_run = 1'b1;
        end else if (cnt == 2'd2) begin
            res[1].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_line_pos  <= '0;
            r_tok_start <= '0;
            r_len       <= '0;
            r_first     <= '0;
            r_num       <= 1'b0;
            r_dot       <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_line_pos  <= n_line_pos;
            r_tok_start <= n_tok_start;
            r_len       <= n_len;
            r_first     <= n_first;
            r_num       <= n_num;
            r_dot       <= n_dot;
            r_ovf       <= n_ovf;
        end
    end

    assign o_push.cnt  = cnt;
    assign o_push.tok0 = res[0];
    assign o_push.tok1 = res[1];

endmodule

`default_nettype wire

[hw/rtl/sxt_outq.sv]
// Result queue: takes up to two tokens per cycle, hands out one per beat.
// Acts as the output register of the tokenizer. Uses sxt_pkg.
`default_nettype none

module sxt_outq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sxt_pkg::t_push i_push,
    input  wire logic          i_pop,
    output sxt_pkg::t_tok      o_head,
    output logic               o_valid,
    output logic               o_no_room,
    output logic [sxt_pkg::Q_CW-1:0] o_cnt
);
    import sxt_pkg::*;

    t_tok              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, n_wp;
    logic [Q_AW-1:0]   r_rp, n_rp;
    logic [Q_CW-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp + Q_AW'(i_push.cnt);
        n_rp  = r_rp + Q_AW'(i_pop);
        n_cnt = r_cnt + Q_CW'(i_push.cnt) - Q_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + 1'b1] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    assign o_head    = r_mem[r_rp];
    assign o_valid   = (r_cnt != '0);
    assign o_no_room = (r_cnt > Q_CW'(Q_DEPTH - 2));
    assign o_cnt     = r_cnt;

endmodule

`default_nettype wire
